### hdl/seam_feather_blend_assert.svh
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef SEAM_FEATHER_BLEND_ASSERT_SVH
`define SEAM_FEATHER_BLEND_ASSERT_SVH

// Clocked check, switched off while reset is held.
`define SFB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define SFB_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/sfb_pkg.sv
// Shared types and constants for the seam feather blender.
// No dependencies.
`timescale 1ns / 1ps
package sfb_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int COL_W       = 12;
    localparam int WID_W       = 13;
    localparam int PIX_W       = 8;
    localparam int NUM_W       = 20;   // 255 * 4096 fits
    localparam int DIV_STEPS   = PIX_W;
    localparam int LANE_LAT    = DIV_STEPS + 2;
    localparam int PIPE_LAT    = LANE_LAT + 2;
    localparam int NUM_CH      = 3;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    typedef enum logic {
        REG_OVERLAP_START = 1'b0,
        REG_LEFT_WIDTH    = 1'b1
    } t_reg_idx;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [WID_W-1:0] start;   // clamped overlap start
        logic [WID_W-1:0] width;   // clamped left width
        logic [WID_W-1:0] span;    // width - start
    } t_geom;

endpackage

### hdl/sfb_cfg.sv
// APB register file plus clamping of the overlap geometry.
// Depends on sfb_pkg.
`timescale 1ns / 1ps
module sfb_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfb_pkg::APB_AW-1:0]    paddr,
    input  logic [sfb_pkg::APB_DW-1:0]    pwdata,
    output logic [sfb_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output sfb_pkg::t_geom                o_geom
);
    import sfb_pkg::*;

    logic [COL_W-1:0] r_overlap_start;
    logic [WID_W-1:0] r_left_width;
    logic [WID_W-1:0] n_width;
    logic [WID_W-1:0] n_start;
    logic             w_wr;
    t_reg_idx         w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overlap_start <= '0;
            r_left_width    <= WID_W'(MAX_COLUMNS);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_OVERLAP_START: r_overlap_start <= pwdata[COL_W-1:0];
                REG_LEFT_WIDTH:    r_left_width    <= pwdata[WID_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_OVERLAP_START: prdata = APB_DW'(r_overlap_start);
            REG_LEFT_WIDTH:    prdata = APB_DW'(r_left_width);
            default:           prdata = '0;
        endcase
    end

    // zero width acts as one, anything past the row limit is clipped
    always_comb begin
        priority if (r_left_width == '0)
            n_width = WID_W'(1);
        else if (r_left_width > WID_W'(MAX_COLUMNS))
            n_width = WID_W'(MAX_COLUMNS);
        else
            n_width = r_left_width;
        n_start = ({1'b0, r_overlap_start} > n_width) ? n_width : {1'b0, r_overlap_start};
    end

    assign o_geom.start = n_start;
    assign o_geom.width = n_width;
    assign o_geom.span  = n_width - n_start;

endmodule

### hdl/sfb_lane.sv
// One color channel: weighted sum, then a pipelined restoring divider.
// Depends on sfb_pkg.
`timescale 1ns / 1ps
module sfb_lane (
    input  logic                        i_clk,
    input  sfb_pkg::t_pix               i_left,
    input  sfb_pkg::t_pix               i_warp,
    input  logic [sfb_pkg::COL_W-1:0]   i_k,
    input  logic [sfb_pkg::WID_W-1:0]   i_wk,
    input  logic [sfb_pkg::WID_W-1:0]   i_span,
    output sfb_pkg::t_pix               o_quo
);
    import sfb_pkg::*;

    localparam int PROD_W = PIX_W + WID_W;

    logic [PROD_W-1:0] w_prod_l;
    logic [PROD_W-1:0] w_prod_w;
    logic [NUM_W-1:0]  r_prod_l;
    logic [NUM_W-1:0]  r_prod_w;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W:0]    w_sum;
    logic [NUM_W-1:0]  r_rem [0:DIV_STEPS-2];
    t_pix              r_quo [0:DIV_STEPS-1];

    assign w_prod_l = PROD_W'(i_left) * PROD_W'(i_wk);
    assign w_prod_w = PROD_W'(i_warp) * PROD_W'(i_k);
    assign w_sum    = {1'b0, r_prod_l} + {1'b0, r_prod_w};

    always_ff @(posedge i_clk) begin
        r_prod_l <= w_prod_l[NUM_W-1:0];
        r_prod_w <= w_prod_w[NUM_W-1:0];
        r_num    <= w_sum[NUM_W-1:0];
    end

    // quotient fits in PIX_W bits, one bit per stage, MSB first
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int SH = DIV_STEPS - 1 - j;
        logic [NUM_W-1:0] w_rem_in;
        t_pix             w_quo_in;
        logic [NUM_W-1:0] w_dvs;
        logic             w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in = r_num;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[j-1];
            assign w_quo_in = r_quo[j-1];
        end

        assign w_dvs = NUM_W'(i_span) << SH;
        assign w_ge  = (w_rem_in >= w_dvs);

        always_ff @(posedge i_clk) begin
            r_quo[j] <= {w_quo_in[PIX_W-2:0], w_ge};
        end

        if (j < DIV_STEPS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[j] <= w_ge ? (w_rem_in - w_dvs) : w_rem_in;
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule

### hdl/seam_feather_blend.sv
// Top level of the seam feather blender: front classify stage, three channel lanes,
// merge stage. Depends on sfb_pkg, sfb_cfg, sfb_lane.
//
//  port group        direction  handshake
//  start / command   in         start && !busy accepts one pixel pair
//  result            out        o_valid strobe, one cycle per pixel
//  APB config        in/out     write at psel && penable && pwrite (pready tied high)
//
// One pixel pair per clock is sustained. From accept to strobe a pixel passes the
// classify register, each lane's product and sum registers and eight-stage divider,
// and the output register. Synchronous active-low reset empties the pipeline;
// busy is high during reset and until r_run is set after it is released.
// Results cannot be held off, so nothing in the pipeline ever stalls.
`timescale 1ns / 1ps
module seam_feather_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sfb_pkg::COL_W-1:0]     i_column,
    input  logic [sfb_pkg::PIX_W-1:0]     i_left_red,
    input  logic [sfb_pkg::PIX_W-1:0]     i_left_green,
    input  logic [sfb_pkg::PIX_W-1:0]     i_left_blue,
    input  logic [sfb_pkg::PIX_W-1:0]     i_warp_red,
    input  logic [sfb_pkg::PIX_W-1:0]     i_warp_green,
    input  logic [sfb_pkg::PIX_W-1:0]     i_warp_blue,
    output logic                          o_valid,
    output logic [sfb_pkg::PIX_W-1:0]     o_out_red,
    output logic [sfb_pkg::PIX_W-1:0]     o_out_green,
    output logic [sfb_pkg::PIX_W-1:0]     o_out_blue,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfb_pkg::APB_AW-1:0]    paddr,
    input  logic [sfb_pkg::APB_DW-1:0]    pwdata,
    output logic [sfb_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import sfb_pkg::*;

    t_geom            w_geom;
    logic             r_run;
    logic             w_accept;
    t_pix             w_left [0:NUM_CH-1];
    t_pix             w_warp [0:NUM_CH-1];
    logic [WID_W-1:0] w_col;
    logic             w_lt_start;
    logic             w_ge_width;
    logic             w_black;
    logic [WID_W-1:0] w_k_full;

    // front stage
    logic             r_f_valid;
    logic             r_f_blend;
    t_pix             r_f_left  [0:NUM_CH-1];
    t_pix             r_f_warp  [0:NUM_CH-1];
    t_pix             r_f_byp   [0:NUM_CH-1];
    logic [COL_W-1:0] r_f_k;
    logic [WID_W-1:0] r_f_wk;

    // side pipe alongside the lanes
    logic             r_d_valid [0:LANE_LAT-1];
    logic             r_d_blend [0:LANE_LAT-1];
    t_pix             r_d_byp   [0:LANE_LAT-1][0:NUM_CH-1];

    t_pix             w_quo [0:NUM_CH-1];
    logic             r_valid;
    t_pix             r_out [0:NUM_CH-1];

    sfb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (w_geom)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_run <= 1'b0;
        else          r_run <= 1'b1;
    end

    assign busy     = !r_run;
    assign w_accept = start && !busy;

    assign w_left[0] = i_left_red;
    assign w_left[1] = i_left_green;
    assign w_left[2] = i_left_blue;
    assign w_warp[0] = i_warp_red;
    assign w_warp[1] = i_warp_green;
    assign w_warp[2] = i_warp_blue;

    assign w_col      = {1'b0, i_column};
    assign w_lt_start = (w_col < w_geom.start);
    assign w_ge_width = (w_col >= w_geom.width);
    assign w_black    = (i_warp_red == '0) && (i_warp_green == '0) && (i_warp_blue == '0);
    assign w_k_full   = w_col - w_geom.start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f_valid <= 1'b0;
        else          r_f_valid <= w_accept;
    end

    // left wins below the overlap and for an empty warped pixel inside it
    always_ff @(posedge i_clk) begin
        r_f_blend <= !w_lt_start && !w_ge_width && !w_black;
        r_f_k     <= w_k_full[COL_W-1:0];
        r_f_wk    <= w_geom.width - w_col;
        for (int c = 0; c < NUM_CH; c++) begin
            r_f_left[c] <= w_left[c];
            r_f_warp[c] <= w_warp[c];
            r_f_byp[c]  <= (w_lt_start || (!w_ge_width && w_black)) ? w_left[c] : w_warp[c];
        end
    end

    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        sfb_lane u_lane (
            .i_clk  (i_clk),
            .i_left (r_f_left[c]),
            .i_warp (r_f_warp[c]),
            .i_k    (r_f_k),
            .i_wk   (r_f_wk),
            .i_span (w_geom.span),
            .o_quo  (w_quo[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LANE_LAT; s++) r_d_valid[s] <= 1'b0;
        end else begin
            r_d_valid[0] <= r_f_valid;
            for (int s = 1; s < LANE_LAT; s++) r_d_valid[s] <= r_d_valid[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_blend[0] <= r_f_blend;
        r_d_byp[0]   <= r_f_byp;
        for (int s = 1; s < LANE_LAT; s++) begin
            r_d_blend[s] <= r_d_blend[s-1];
            r_d_byp[s]   <= r_d_byp[s-1];
        end
    end

    // merge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= r_d_valid[LANE_LAT-1];
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CH; c++) begin
            r_out[c] <= r_d_blend[LANE_LAT-1] ? w_quo[c] : r_d_byp[LANE_LAT-1][c];
        end
    end

    assign o_valid     = r_valid;
    assign o_out_red   = r_out[0];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[2];

endmodule

### hdl/sfb_checker.sv
// Port-level checks for seam_feather_blend, attached by bind.
// Depends on sfb_pkg and seam_feather_blend_assert.svh.
`timescale 1ns / 1ps
`include "seam_feather_blend_assert.svh"
module sfb_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          o_valid,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfb_pkg::APB_AW-1:0]    paddr,
    input  logic [sfb_pkg::APB_DW-1:0]    pwdata,
    input  logic [sfb_pkg::APB_DW-1:0]    prdata
);
    import sfb_pkg::*;

    // every accepted transaction gives a strobe after the fixed latency
    `SFB_ASSERT(a_latency_fwd, (start && !busy) |-> ##PIPE_LAT o_valid, "result strobe missing")

    // no strobe without a matching transaction
    `SFB_ASSERT(a_latency_bwd, o_valid |-> $past(start && !busy, PIPE_LAT), "spurious result strobe")

    // reset empties the pipeline and blocks new transactions
    `SFB_ASSERT_RST(a_reset_flush, !i_rst_n |=> (busy && !o_valid), "pipeline not flushed by reset")

    // a write to the overlap start reads back on the next cycle
    `SFB_ASSERT(a_start_readback, (psel && penable && pwrite && !paddr[2]) |=> (paddr[2] || (prdata[COL_W-1:0] == $past(pwdata[COL_W-1:0]))), "overlap start readback mismatch")

endmodule

bind seam_feather_blend sfb_checker u_sfb_checker (.*);

### test/tb_top.sv
// Self-checking bench for seam_feather_blend: pixel pairs driven through the command port,
// stitched pixels compared against a predictor of the feather blend, APB set between phases.
// Depends on sfb_pkg and the seam_feather_blend RTL.
`timescale 1ns / 1ps
module tb_top;
    import sfb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [COL_W-1:0] column;
        t_pix             left_red;
        t_pix             left_green;
        t_pix             left_blue;
        t_pix             warp_red;
        t_pix             warp_green;
        t_pix             warp_blue;
        logic [3:0]       gap;        // idle cycles ahead of this pair
    } t_pixel_pair;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
    } t_stitched_px;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [COL_W-1:0]   i_column;
    t_pix               i_left_red, i_left_green, i_left_blue;
    t_pix               i_warp_red, i_warp_green, i_warp_blue;
    logic               o_valid;
    t_pix               o_out_red, o_out_green, o_out_blue;
    logic               psel, penable, pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    seam_feather_blend uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_column     (i_column),
        .i_left_red   (i_left_red),
        .i_left_green (i_left_green),
        .i_left_blue  (i_left_blue),
        .i_warp_red   (i_warp_red),
        .i_warp_green (i_warp_green),
        .i_warp_blue  (i_warp_blue),
        .o_valid      (o_valid),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 i_clk = ~i_clk;

    // local copy of the two registers
    logic [COL_W-1:0]   seam_start_reg = '0;
    logic [WID_W-1:0]   left_width_reg = 13'd4096;

    t_pixel_pair        pair_backlog[$];
    t_stitched_px       stitched_due[$];
    int unsigned        mismatch_cnt = 0;

    function automatic void queue_pair(t_pixel_pair p);
        pair_backlog.insert(pair_backlog.size(), p);
    endfunction

    // width clamped to 1..MAX_COLUMNS, start clamped to width
    function automatic void overlap_bounds(output int unsigned lo, output int unsigned hi);
        hi = left_width_reg;
        if (hi < 1) hi = 1;
        if (hi > MAX_COLUMNS) hi = MAX_COLUMNS;
        lo = seam_start_reg;
        if (lo > hi) lo = hi;
    endfunction

    function automatic t_pix feather_channel(t_pix l, t_pix r, int unsigned k, int unsigned span);
        longint unsigned num;
        num = longint'(l) * (span - k) + longint'(r) * k;
        return t_pix'(num / span);
    endfunction

    function automatic t_stitched_px stitch_pixel(t_pixel_pair p);
        int unsigned  lo, hi, k, span;
        t_stitched_px px;
        overlap_bounds(lo, hi);
        if (p.column < lo) begin
            px = '{p.left_red, p.left_green, p.left_blue};
        end else if (p.column >= hi) begin
            px = '{p.warp_red, p.warp_green, p.warp_blue};
        end else if (p.warp_red == 0 && p.warp_green == 0 && p.warp_blue == 0) begin
            // black warped pixel counts as empty
            px = '{p.left_red, p.left_green, p.left_blue};
        end else begin
            k    = p.column - lo;
            span = hi - lo;
            px.red   = feather_channel(p.left_red, p.warp_red, k, span);
            px.green = feather_channel(p.left_green, p.warp_green, k, span);
            px.blue  = feather_channel(p.left_blue, p.warp_blue, k, span);
        end
        return px;
    endfunction

    // ---------------- driver ----------------
    t_pixel_pair  shown_pair;
    t_pixel_pair  queued_pair;
    bit           presenting = 0;
    bit           have_queued = 0;
    int unsigned  hold_cnt = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start       <= 1'b0;
            presenting  = 0;
            have_queued = 0;
            hold_cnt    = 0;
        end else begin
            if (start && !busy) begin
                stitched_due.insert(stitched_due.size(), stitch_pixel(shown_pair));
                presenting = 0;
            end
            if (!presenting) begin
                if (!have_queued && pair_backlog.size() != 0) begin
                    queued_pair = pair_backlog.pop_front();
                    hold_cnt    = queued_pair.gap;
                    have_queued = 1;
                end
                if (have_queued && hold_cnt == 0) begin
                    start        <= 1'b1;
                    i_column     <= queued_pair.column;
                    i_left_red   <= queued_pair.left_red;
                    i_left_green <= queued_pair.left_green;
                    i_left_blue  <= queued_pair.left_blue;
                    i_warp_red   <= queued_pair.warp_red;
                    i_warp_green <= queued_pair.warp_green;
                    i_warp_blue  <= queued_pair.warp_blue;
                    shown_pair   = queued_pair;
                    presenting   = 1;
                    have_queued  = 0;
                end else begin
                    start <= 1'b0;
                    if (have_queued) hold_cnt--;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_stitched_px want;
        if (i_rst_n && o_valid) begin
            if (stitched_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: r=%0d g=%0d b=%0d",
                             o_out_red, o_out_green, o_out_blue);
            end else begin
                want = stitched_due.pop_front();
                if (o_out_red !== want.red || o_out_green !== want.green ||
                    o_out_blue !== want.blue) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 want.red, want.green, want.blue,
                                 o_out_red, o_out_green, o_out_blue);
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    int unsigned stall_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("seam_feather_blend test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(t_reg_idx idx, int unsigned value);
        logic [APB_DW-1:0] keep;
        keep = (idx == REG_OVERLAP_START) ? APB_DW'((1 << COL_W) - 1)
                                          : APB_DW'((1 << WID_W) - 1);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // junk above the field must be ignored
        pwdata  <= ($urandom() & ~keep) | (value & keep);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_OVERLAP_START) seam_start_reg = COL_W'(value);
        else left_width_reg = WID_W'(value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait until every transaction is in and every result is out
    task automatic drain();
        while (pair_backlog.size() != 0 || have_queued || presenting ||
               stitched_due.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    function automatic t_pix any_channel();
        case ($urandom_range(0, 6))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return t_pix'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_pixel_pair pair_of(int unsigned col, int unsigned lr, int unsigned lg,
                                            int unsigned lb, int unsigned wr, int unsigned wg,
                                            int unsigned wb);
        t_pixel_pair p;
        p.column     = COL_W'(col);
        p.left_red   = t_pix'(lr);
        p.left_green = t_pix'(lg);
        p.left_blue  = t_pix'(lb);
        p.warp_red   = t_pix'(wr);
        p.warp_green = t_pix'(wg);
        p.warp_blue  = t_pix'(wb);
        p.gap        = 4'($urandom_range(0, 15));
        return p;
    endfunction

    function automatic t_pixel_pair random_pair(bit back_to_back);
        int unsigned lo, hi, col;
        t_pixel_pair p;
        overlap_bounds(lo, hi);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: col = (hi > lo) ? $urandom_range(hi - 1, lo) : $urandom_range(0, 4095);
            5:       col = $urandom_range(1, 0) ? lo : lo - 1;
            6:       col = $urandom_range(1, 0) ? hi : hi - 1;
            default: col = $urandom_range(0, 4095);
        endcase
        if (col > 4095) col = $urandom_range(1, 0) ? 0 : 4095;
        p = pair_of(col, any_channel(), any_channel(), any_channel(),
                    any_channel(), any_channel(), any_channel());
        if ($urandom_range(0, 7) == 0) begin
            p.warp_red   = '0;
            p.warp_green = '0;
            p.warp_blue  = '0;
        end
        if (back_to_back || $urandom_range(0, 2) == 0) p.gap = '0;
        return p;
    endfunction

    task automatic random_phase(int unsigned seam, int unsigned width, int unsigned count);
        bit back_to_back;
        write_reg(REG_OVERLAP_START, seam);
        write_reg(REG_LEFT_WIDTH, width);
        back_to_back = ($urandom_range(0, 3) == 0);
        repeat (count) queue_pair(random_pair(back_to_back));
        drain();
    endtask

    initial begin
        int unsigned w;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_column     = '0;
        i_left_red   = '0;
        i_left_green = '0;
        i_left_blue  = '0;
        i_warp_red   = '0;
        i_warp_green = '0;
        i_warp_blue  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: overlap spans the whole row
        queue_pair(pair_of(0, 255, 0, 128, 1, 2, 3));
        queue_pair(pair_of(4095, 0, 255, 7, 255, 0, 200));
        queue_pair(pair_of(2048, 255, 255, 255, 255, 255, 255));
        queue_pair(pair_of(1000, 9, 80, 250, 0, 0, 0));
        drain();

        // overlap of 256 columns starting at 100
        write_reg(REG_OVERLAP_START, 100);
        write_reg(REG_LEFT_WIDTH, 356);
        queue_pair(pair_of(0, 10, 20, 30, 40, 50, 60));
        queue_pair(pair_of(99, 255, 255, 255, 1, 1, 1));
        queue_pair(pair_of(100, 200, 100, 50, 255, 255, 255));
        queue_pair(pair_of(101, 255, 255, 255, 0, 0, 1));
        queue_pair(pair_of(228, 0, 128, 255, 255, 128, 0));
        queue_pair(pair_of(355, 0, 0, 0, 255, 255, 255));
        queue_pair(pair_of(355, 255, 255, 255, 0, 1, 0));
        queue_pair(pair_of(356, 11, 22, 33, 0, 0, 0));
        queue_pair(pair_of(4095, 1, 2, 3, 254, 253, 252));
        queue_pair(pair_of(200, 77, 88, 99, 0, 0, 0));
        queue_pair(pair_of(300, 255, 255, 255, 255, 255, 255));
        drain();

        // width zero behaves as one, start above width is clamped
        write_reg(REG_OVERLAP_START, 4095);
        write_reg(REG_LEFT_WIDTH, 0);
        queue_pair(pair_of(0, 5, 6, 7, 8, 9, 10));
        queue_pair(pair_of(1, 5, 6, 7, 8, 9, 10));
        drain();
        // width above the row limit is cut to it
        write_reg(REG_LEFT_WIDTH, 8191);
        queue_pair(pair_of(4094, 5, 6, 7, 8, 9, 10));
        queue_pair(pair_of(4095, 250, 6, 7, 8, 9, 0));
        drain();

        random_phase(100, 356, 70);
        random_phase(0, 4096, 70);
        random_phase(4095, 4096, 60);
        random_phase(0, 1, 60);
        random_phase(0, 0, 50);
        random_phase(3000, 8191, 70);
        random_phase(500, 200, 60);
        random_phase(2000, 2001, 60);
        random_phase(4095, 5000, 50);
        random_phase(1, 4095, 70);
        repeat (5) begin
            w = $urandom_range(1, 4096);
            random_phase($urandom_range(0, w), w, 66);
        end

        drain();
        if (mismatch_cnt == 0)
            $display("seam_feather_blend test passed");
        else
            $display("seam_feather_blend test failed");
        $finish;
    end

endmodule
